/* design/lzw_pkg.sv */
// ----------------------------------------------------------------------------
// lzw_pkg: shared types and constants of the LZW byte encoder
// Request payload structs and the fixed code constants.
// ----------------------------------------------------------------------------
package lzw_pkg;

	// First code handed out for a multi-byte string
	localparam int unsigned FIRST_CODE = 256;
	// Width of an emitted code
	localparam int unsigned CODE_W     = 12;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} lzw_in_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last_code;
	} lzw_out_t;

endpackage

/* design/lzw_byte_encoder_top.sv */
// ----------------------------------------------------------------------------
// lzw_byte_encoder_top: LZW encoder, one byte per request
// Dictionary of (prefix, byte) pairs indexed by code, plus an open-addressed
// hash table of codes that finds a pair by linear probing.
// ----------------------------------------------------------------------------
// A byte with no prefix pending is taken as the prefix on accept. Otherwise the accept cycle is
// followed per probe by a hash read and, on a slot holding a live code, a dictionary
// read; a miss adds an emit step and the final byte a flush step, both held by out_ready.
// One request in flight: in_ready is high only in IDLE, so a new byte waits for the last.
// Reset clears control state and zeroes the hash table slot by slot, 2^(clog2(DICT_SIZE)+1)
// slots (8192 by default), with in_ready low; stale entries fail a range and back-pointer check.
module lzw_byte_encoder_top #(
	parameter int unsigned DICT_SIZE = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lzw_pkg::lzw_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lzw_pkg::lzw_out_t out_data
);
	import lzw_pkg::*;

	localparam int unsigned CW     = $clog2(DICT_SIZE);
	localparam int unsigned HW     = CW + 1;
	localparam int unsigned HSLOTS = 1 << HW;
	localparam int unsigned DSLOTS = DICT_SIZE - FIRST_CODE;
	localparam int unsigned DW     = $clog2(DSLOTS);

	typedef struct packed {
		logic [CW-1:0] prefix;
		logic [7:0]    data;
		logic [HW-1:0] slot;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_HREAD = 6'b000010,
		ST_DREAD = 6'b000100,
		ST_EMIT  = 6'b001000,
		ST_FLUSH = 6'b010000,
		ST_CLEAR = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [7:0]    byte_q;
	logic          eos_q;
	logic [HW-1:0] slot_q;
	logic [CW-1:0] cand_q;
	logic [CW-1:0] prefix_q;
	logic          pvalid_q;
	logic [CW:0]   nfc_q;
	logic [HW-1:0] clr_q;
	lzw_out_t      out_q;
	logic          out_valid_q;

	logic [CW-1:0] hmem [HSLOTS];
	entry_t        dmem [DSLOTS];
	logic [CW-1:0] hrd_q;
	entry_t        drd_q;

	logic [HW-1:0] haddr;
	logic [DW-1:0] daddr;
	logic          hwr_en;
	logic          cand_in_range;
	logic          slot_live;
	logic          key_hit;
	logic          out_free;
	logic          dict_room;
	logic          in_accept;
	logic          out_load;
	lzw_out_t      out_d;

	assign in_ready  = state_q == ST_IDLE;
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign dict_room = nfc_q < (CW+1)'(DICT_SIZE);

	// Check the code read from the hash table against the live code range
	assign cand_in_range = (hrd_q >= CW'(FIRST_CODE)) && ({1'b0, hrd_q} < nfc_q);
	// A slot is live only if its code's entry points back to it
	assign slot_live = drd_q.slot == slot_q;
	assign key_hit   = slot_live && drd_q.prefix == prefix_q && drd_q.data == byte_q;

	// Select hash table read address: home slot on accept, next slot on probe
	always_comb begin
		if (state_q == ST_IDLE) begin
			haddr = HW'(prefix_q) ^ (HW'(in_data.data_byte) << (HW - 8));
		end else begin
			haddr = slot_q + HW'(1);
		end
	end

	assign daddr  = DW'(hrd_q - CW'(FIRST_CODE));
	assign hwr_en = (state_q == ST_EMIT) && out_free && dict_room;

	// Read and write back the hash table; zero it slot by slot after reset
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			hmem[clr_q] <= '0;
		end else if (hwr_en) begin
			hmem[slot_q] <= nfc_q[CW-1:0];
		end
		hrd_q <= hmem[haddr];
	end

	// Read and write back the dictionary
	always_ff @(posedge clk) begin
		if (hwr_en) begin
			dmem[DW'(nfc_q - (CW+1)'(FIRST_CODE))] <= '{prefix: prefix_q, data: byte_q,
				slot: slot_q};
		end
		drd_q <= dmem[daddr];
	end

	// Sequence the hash table clear after reset, and one request through probe, emit and flush
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d    = out_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					if (!pvalid_q) begin
						state_d = in_data.end_of_stream ? ST_FLUSH : ST_IDLE;
					end else begin
						state_d = ST_HREAD;
					end
				end
			end
			ST_HREAD: begin
				state_d = cand_in_range ? ST_DREAD : ST_EMIT;
			end
			ST_DREAD: begin
				priority if (key_hit) begin
					state_d = eos_q ? ST_FLUSH : ST_IDLE;
				end else if (slot_live) begin
					state_d = ST_HREAD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{code: CODE_W'(prefix_q), last_code: 1'b0};
					state_d  = eos_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{code: CODE_W'(prefix_q), last_code: 1'b1};
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pvalid_q    <= 1'b0;
			nfc_q       <= (CW+1)'(FIRST_CODE);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + HW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept && !pvalid_q) begin
				pvalid_q <= 1'b1;
			end
			if (hwr_en) begin
				nfc_q <= nfc_q + (CW+1)'(1);
			end
			if (state_q == ST_FLUSH && out_free) begin
				pvalid_q <= 1'b0;
				nfc_q    <= (CW+1)'(FIRST_CODE);
			end
		end
	end

	// Advance payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_q <= in_data.data_byte;
			eos_q  <= in_data.end_of_stream;
			slot_q <= haddr;
			if (!pvalid_q) begin
				prefix_q <= CW'(in_data.data_byte);
			end
		end
		if (state_q == ST_HREAD) begin
			cand_q <= hrd_q;
		end
		if (state_q == ST_DREAD) begin
			if (key_hit) begin
				prefix_q <= cand_q;
			end else if (slot_live) begin
				slot_q <= haddr;
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			prefix_q <= CW'(byte_q);
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// Probed candidate code always lies in the live code range
	a_cand_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DREAD |-> cand_q >= CW'(FIRST_CODE) && {1'b0, cand_q} < nfc_q)
		else $error("probed code outside live range");

	// Next free code stays between the first code and the dictionary size
	a_nfc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q >= (CW+1)'(FIRST_CODE) && nfc_q <= (CW+1)'(DICT_SIZE))
		else $error("next free code out of bounds");

	// Flush restarts the stream
	a_flush_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH && out_free |=> !pvalid_q && nfc_q == (CW+1)'(FIRST_CODE)
		&& out_valid_q && out_q.last_code)
		else $error("flush did not restart stream");

	// First byte of a stream becomes the prefix
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !pvalid_q && !in_data.end_of_stream |=>
		pvalid_q && prefix_q == CW'($past(in_data.data_byte)))
		else $error("first byte not taken as prefix");

	// Emitting a miss result loads a non-final code
	a_emit_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free |=> out_valid_q && !out_q.last_code
		&& out_q.code == CODE_W'($past(prefix_q)))
		else $error("miss result mismatch");

endmodule
